// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the complex arithmetic unit rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
// package of the complex arithmetic unit: action and status codes, control struct
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MAG = 3'd4
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } st_e;

  // control word that travels with an item through the cell chain
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             neg_re;
    logic             neg_im;
    logic             ovf_re;
    logic             ovf_im;
    logic             dz;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cau_if.sv =====
// valid/ready stream interfaces for operand and result transfers
// depends on cau_pkg
`default_nettype none

interface cau_in_if #(
  parameter int unsigned DATA_WIDTH = 32
) ();
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [ACT_W-1:0]             action;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
  parameter int unsigned DATA_WIDTH = 32
) ();
  import cau_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_real;
  logic signed [DATA_WIDTH-1:0] res_imag;
  logic [STATUS_W-1:0]          status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit_top.sv =====
// complex arithmetic unit, pipelined from operand transfer to result valid; throughput one
// item per cycle unless the result is held back: four front stages, a chain of DATA_WIDTH
// cells that each settle one quotient bit or one root step, then the result register; every
// stage advances on its own so bubbles close up and an item is taken while a result waits
// reset (asynchronous, active low) clears all stage valid flags; no result is pending after it
`default_nettype none

module complex_arithmetic_unit_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  localparam int unsigned MW = 2 * DATA_WIDTH;
  localparam int unsigned NW = MW + DATA_WIDTH + FRAC_BITS;

  // chain links, index 0 is the front end output
  logic                  vld   [DATA_WIDTH+1];
  logic                  rdy   [DATA_WIDTH+1];
  ctl_t                  ctl   [DATA_WIDTH+1];
  logic [NW-1:0]         rem_re[DATA_WIDTH+1];
  logic [NW-1:0]         rem_im[DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q_re  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q_im  [DATA_WIDTH+1];
  logic [MW-1:0]         dv    [DATA_WIDTH+1];

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .action_i(in_i.action),
    .a_real_i(in_i.a_real),
    .a_imag_i(in_i.a_imag),
    .b_real_i(in_i.b_real),
    .b_imag_i(in_i.b_imag),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .ctl_o   (ctl[0]),
    .rem_re_o(rem_re[0]),
    .rem_im_o(rem_im[0]),
    .d_o     (dv[0])
  );

  // quotient and root cells, most significant bit first
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    cau_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .STEP      (DATA_WIDTH - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .ctl_i   (ctl[k]),
      .rem_re_i(rem_re[k]),
      .rem_im_i(rem_im[k]),
      .q_re_i  (q_re[k]),
      .q_im_i  (q_im[k]),
      .d_i     (dv[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .ctl_o   (ctl[k+1]),
      .rem_re_o(rem_re[k+1]),
      .rem_im_o(rem_im[k+1]),
      .q_re_o  (q_re[k+1]),
      .q_im_o  (q_im[k+1]),
      .d_o     (dv[k+1])
    );
  end

  cau_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld[DATA_WIDTH]),
    .ready_o   (rdy[DATA_WIDTH]),
    .ctl_i     (ctl[DATA_WIDTH]),
    .rem_re_i  (rem_re[DATA_WIDTH]),
    .rem_im_i  (rem_im[DATA_WIDTH]),
    .q_re_i    (q_re[DATA_WIDTH]),
    .q_im_i    (q_im[DATA_WIDTH]),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_real_o(out_o.res_real),
    .res_imag_o(out_o.res_imag),
    .status_o  (out_o.status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// front end of the complex arithmetic unit: products, sums, magnitudes, chain entry
// depends on cau_pkg
`default_nettype none

module cau_front #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [cau_pkg::ACT_W-1:0]        action_i,
  input  logic signed [DATA_WIDTH-1:0]     a_real_i,
  input  logic signed [DATA_WIDTH-1:0]     a_imag_i,
  input  logic signed [DATA_WIDTH-1:0]     b_real_i,
  input  logic signed [DATA_WIDTH-1:0]     b_imag_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output cau_pkg::ctl_t                    ctl_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_o,
  output logic [2*DATA_WIDTH-1:0]          d_o
);
  import cau_pkg::*;

  localparam int unsigned MW = 2 * DATA_WIDTH;
  localparam int unsigned SW = MW + 1;
  localparam int unsigned NW = MW + DATA_WIDTH + FRAC_BITS;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage enables: a stage loads when empty or when its content moves on
  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: six products, squares taken of the divisor or of the first operand
  logic signed [DATA_WIDTH-1:0] sq_x, sq_y;
  logic [ACT_W-1:0]             act1_q;
  logic signed [MW-1:0]         p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DATA_WIDTH-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  assign sq_x = (action_i == ACT_DIV) ? b_real_i : a_real_i;
  assign sq_y = (action_i == ACT_DIV) ? b_imag_i : a_imag_i;

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      act1_q <= action_i;
      p0_q   <= a_real_i * b_real_i;
      p1_q   <= a_imag_i * b_imag_i;
      p2_q   <= a_real_i * b_imag_i;
      p3_q   <= a_imag_i * b_real_i;
      p4_q   <= sq_x * sq_x;
      p5_q   <= sq_y * sq_y;
      ar1_q  <= a_real_i;
      ai1_q  <= a_imag_i;
      br1_q  <= b_real_i;
      bi1_q  <= b_imag_i;
    end
  end

  // stage 2: signed sums per action and the sum of squares
  logic signed [SW-1:0] re2_d, im2_d, re2_q, im2_q;
  logic [MW-1:0]        sq2_d, sq2_q;
  logic [ACT_W-1:0]     act2_q;

  always_comb begin
    re2_d = '0;
    im2_d = '0;
    unique case (act1_q)
      ACT_ADD: begin
        re2_d = SW'(ar1_q) + SW'(br1_q);
        im2_d = SW'(ai1_q) + SW'(bi1_q);
      end
      ACT_SUB: begin
        re2_d = SW'(ar1_q) - SW'(br1_q);
        im2_d = SW'(ai1_q) - SW'(bi1_q);
      end
      ACT_MUL: begin
        re2_d = SW'(p0_q) - SW'(p1_q);
        im2_d = SW'(p2_q) + SW'(p3_q);
      end
      ACT_DIV: begin
        re2_d = SW'(p0_q) + SW'(p1_q);
        im2_d = SW'(p3_q) - SW'(p2_q);
      end
      default: begin
        re2_d = '0;
        im2_d = '0;
      end
    endcase
    sq2_d = $unsigned(p4_q) + $unsigned(p5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      act2_q <= act1_q;
      re2_q  <= re2_d;
      im2_q  <= im2_d;
      sq2_q  <= sq2_d;
    end
  end

  // stage 3: sign and magnitude, products truncated toward zero
  logic [MW-1:0]    mag_re3_d, mag_im3_d, mag_re3_q, mag_im3_q, sq3_q;
  logic             neg_re3_q, neg_im3_q, dz3_q;
  logic [ACT_W-1:0] act3_q;

  always_comb begin
    mag_re3_d = MW'(re2_q[SW-1] ? -re2_q : re2_q);
    mag_im3_d = MW'(im2_q[SW-1] ? -im2_q : im2_q);
    if (act2_q == ACT_MUL) begin
      mag_re3_d = mag_re3_d >> FRAC_BITS;
      mag_im3_d = mag_im3_d >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      act3_q    <= act2_q;
      neg_re3_q <= re2_q[SW-1];
      neg_im3_q <= im2_q[SW-1];
      mag_re3_q <= mag_re3_d;
      mag_im3_q <= mag_im3_d;
      sq3_q     <= sq2_q;
      dz3_q     <= (sq2_q == '0);
    end
  end

  // stage 4: scaled numerators, quotient overflow check, chain entry values
  logic [NW-1:0] num_re, num_im, dsh;
  logic [NW-1:0] rem_re4_d, rem_im4_d;
  ctl_t          ctl4_d;

  assign num_re = NW'(mag_re3_q) << FRAC_BITS;
  assign num_im = NW'(mag_im3_q) << FRAC_BITS;
  assign dsh    = NW'(sq3_q) << DATA_WIDTH;

  always_comb begin
    ctl4_d.act    = act3_q;
    ctl4_d.neg_re = neg_re3_q;
    ctl4_d.neg_im = neg_im3_q;
    ctl4_d.ovf_re = (act3_q == ACT_DIV) && (num_re >= dsh);
    ctl4_d.ovf_im = (act3_q == ACT_DIV) && (num_im >= dsh);
    ctl4_d.dz     = (act3_q == ACT_DIV) && dz3_q;
    if (act3_q == ACT_DIV) begin
      rem_re4_d = num_re;
      rem_im4_d = num_im;
    end else if (act3_q == ACT_MAG) begin
      rem_re4_d = NW'(sq3_q);
      rem_im4_d = '0;
    end else begin
      rem_re4_d = NW'(mag_re3_q);
      rem_im4_d = NW'(mag_im3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      ctl_o    <= ctl4_d;
      rem_re_o <= rem_re4_d;
      rem_im_o <= rem_im4_d;
      d_o      <= sq3_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cau_cell.sv =====
// one cell of the quotient and root chain: one quotient bit per lane or one root step
// depends on cau_pkg
`default_nettype none

module cau_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned STEP       = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  cau_pkg::ctl_t                     ctl_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_i,
  input  logic [DATA_WIDTH-1:0]             q_re_i,
  input  logic [DATA_WIDTH-1:0]             q_im_i,
  input  logic [2*DATA_WIDTH-1:0]           d_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output cau_pkg::ctl_t                     ctl_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_o,
  output logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_o,
  output logic [DATA_WIDTH-1:0]             q_re_o,
  output logic [DATA_WIDTH-1:0]             q_im_o,
  output logic [2*DATA_WIDTH-1:0]           d_o
);
  import cau_pkg::*;

  localparam int unsigned MW = 2 * DATA_WIDTH;
  localparam int unsigned NW = MW + DATA_WIDTH + FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] QBIT = DATA_WIDTH'(1) << STEP;
  localparam logic [MW-1:0]         ONE  = MW'(1) << (2 * STEP);

  logic v_q, en;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  // restoring division step against the divisor shifted to this bit
  logic [NW-1:0] dsh;
  logic          ge_re, ge_im;

  assign dsh   = NW'(d_i) << STEP;
  assign ge_re = rem_re_i >= dsh;
  assign ge_im = rem_im_i >= dsh;

  // square root step: remainder in the real lane, root in the imaginary lane
  logic [MW-1:0] sx, sres, sx_n, sres_n;
  logic [MW:0]   st;
  logic          take;

  assign sx     = rem_re_i[MW-1:0];
  assign sres   = rem_im_i[MW-1:0];
  assign st     = {1'b0, sres} + {1'b0, ONE};
  assign take   = {1'b0, sx} >= st;
  assign sx_n   = take ? sx - st[MW-1:0] : sx;
  assign sres_n = take ? (sres >> 1) + ONE : sres >> 1;

  // select by action
  logic [NW-1:0]         rem_re_d, rem_im_d;
  logic [DATA_WIDTH-1:0] q_re_d, q_im_d;

  always_comb begin
    rem_re_d = rem_re_i;
    rem_im_d = rem_im_i;
    q_re_d   = q_re_i;
    q_im_d   = q_im_i;
    if (ctl_i.act == ACT_DIV) begin
      rem_re_d = ge_re ? rem_re_i - dsh : rem_re_i;
      rem_im_d = ge_im ? rem_im_i - dsh : rem_im_i;
      q_re_d   = ge_re ? q_re_i | QBIT : q_re_i;
      q_im_d   = ge_im ? q_im_i | QBIT : q_im_i;
    end else if (ctl_i.act == ACT_MAG) begin
      rem_re_d = NW'(sx_n);
      rem_im_d = NW'(sres_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      ctl_o    <= ctl_i;
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
      d_o      <= d_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cau_back.sv =====
// back end of the complex arithmetic unit: saturation, status and result register
// depends on cau_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cau_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  cau_pkg::ctl_t                     ctl_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_re_i,
  input  logic [3*DATA_WIDTH+FRAC_BITS-1:0] rem_im_i,
  input  logic [DATA_WIDTH-1:0]             q_re_i,
  input  logic [DATA_WIDTH-1:0]             q_im_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [DATA_WIDTH-1:0]      res_real_o,
  output logic signed [DATA_WIDTH-1:0]      res_imag_o,
  output logic [cau_pkg::STATUS_W-1:0]      status_o
);
  import cau_pkg::*;

  localparam int unsigned MW = 2 * DATA_WIDTH;
  localparam int unsigned EW = MW + 1;
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // saturate a sign and magnitude pair, overflow flag on top
  function automatic logic [DATA_WIDTH:0] encode(input logic neg, input logic [EW-1:0] mag);
    logic [EW-1:0]         lim;
    logic [DATA_WIDTH-1:0] lo;
    logic                  ovf;
    lim = (EW'(1) << (DATA_WIDTH - 1)) - EW'(!neg);
    ovf = mag > lim;
    lo  = ovf ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    return {ovf, neg ? -lo : lo};
  endfunction

  logic [EW-1:0]         mag_re, mag_im;
  logic                  neg_re, neg_im, known;
  logic [DATA_WIDTH:0]   enc_re, enc_im;
  logic [DATA_WIDTH-1:0] res_re_d, res_im_d;
  logic [STATUS_W-1:0]   status_d;

  // magnitudes by action
  always_comb begin
    mag_re = '0;
    mag_im = '0;
    neg_re = ctl_i.neg_re;
    neg_im = ctl_i.neg_im;
    known  = 1'b1;
    unique case (ctl_i.act)
      ACT_ADD, ACT_SUB, ACT_MUL: begin
        mag_re = EW'(rem_re_i[MW-1:0]);
        mag_im = EW'(rem_im_i[MW-1:0]);
      end
      ACT_DIV: begin
        mag_re = ctl_i.ovf_re ? '1 : EW'(q_re_i);
        mag_im = ctl_i.ovf_im ? '1 : EW'(q_im_i);
      end
      ACT_MAG: begin
        mag_re = EW'(rem_im_i[MW-1:0]);
        neg_re = 1'b0;
        neg_im = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // saturation and status
  always_comb begin
    enc_re = encode(neg_re, mag_re);
    enc_im = encode(neg_im, mag_im);
    if (ctl_i.dz) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DZ;
    end else if (known) begin
      res_re_d = enc_re[DATA_WIDTH-1:0];
      res_im_d = enc_im[DATA_WIDTH-1:0];
      status_d = (enc_re[DATA_WIDTH] || enc_im[DATA_WIDTH]) ? ST_SAT : ST_OK;
    end else begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_OK;
    end
  end

  // result register, loads when empty or when its transfer completes
  logic                  v_q, en;
  logic [DATA_WIDTH-1:0] res_re_q, res_im_q;
  logic [STATUS_W-1:0]   status_q;
  logic [ACT_W-1:0]      act_q;

  assign en         = !v_q || ready_i;
  assign ready_o    = en;
  assign valid_o    = v_q;
  assign res_real_o = res_re_q;
  assign res_imag_o = res_im_q;
  assign status_o   = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
      act_q    <= ctl_i.act;
    end
  end

  // checks
  `CAU_ASSERT(a_dz_zero, v_q && status_q == ST_DZ |-> res_re_q == '0 && res_im_q == '0, "divide by zero with nonzero result")
  `CAU_ASSERT(a_sat_limit, v_q && status_q == ST_SAT |-> res_re_q == MAXV || res_re_q == MINV || res_im_q == MAXV || res_im_q == MINV, "saturation flagged without a limit value")
  `CAU_ASSERT(a_mag_sign, v_q && act_q == ACT_MAG |-> res_im_q == '0 && !res_re_q[DATA_WIDTH-1], "magnitude negative or with imaginary part")
  `CAU_ASSERT_NEXT(a_capture, valid_i && en, v_q, "offered item not captured")

endmodule

`default_nettype wire
